// File: sv/cdr_pkg.sv
package cdr_pkg;

    localparam int BUFFER_BYTES_DEF = 512;
    localparam int ANSWER_BYTES     = 16;
    localparam int HEADER_BYTES     = 12;

    // answer record constants
    localparam logic [15:0] ANS_NAME_PTR = 16'hC00C;
    localparam logic [15:0] ANS_TYPE_A   = 16'h0001;
    localparam logic [15:0] ANS_CLASS_IN = 16'h0001;
    localparam logic [31:0] ANS_TTL      = 32'd60;
    localparam logic [15:0] ANS_RDLEN    = 16'd4;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_PULL    = 1'b1;

    typedef enum logic [1:0] {
        KIND_VERDICT = 2'd0,
        KIND_BYTE    = 2'd1,
        KIND_EMPTY   = 2'd2
    } t_kind;

    localparam logic [2:0] VERDICT_ANSWERED  = 3'd0;
    localparam logic [2:0] VERDICT_SHORT     = 3'd1;
    localparam logic [2:0] VERDICT_COUNTS    = 3'd2;
    localparam logic [2:0] VERDICT_NOT_QUERY = 3'd3;
    localparam logic [2:0] VERDICT_TOO_LONG  = 3'd4;

    typedef struct packed {
        logic write_byte;  // store one request byte
        logic pull_read;   // read the store at the read pointer
        logic decide;      // judge the request, emit the verdict
        logic emit_empty;  // emit a nothing-pending result
        logic emit_byte;   // emit one response byte
    } t_cmd;

    typedef struct packed {
        logic pending;     // a response waits to be read out
    } t_status;

    // fixed part of the answer record, before the address
    function automatic logic [7:0] tail_byte(input logic [3:0] k);
        logic [7:0] b;
        b = 8'h00;
        case (k)
            4'd0:    b = ANS_NAME_PTR[15:8];
            4'd1:    b = ANS_NAME_PTR[7:0];
            4'd2:    b = ANS_TYPE_A[15:8];
            4'd3:    b = ANS_TYPE_A[7:0];
            4'd4:    b = ANS_CLASS_IN[15:8];
            4'd5:    b = ANS_CLASS_IN[7:0];
            4'd6:    b = ANS_TTL[31:24];
            4'd7:    b = ANS_TTL[23:16];
            4'd8:    b = ANS_TTL[15:8];
            4'd9:    b = ANS_TTL[7:0];
            4'd10:   b = ANS_RDLEN[15:8];
            4'd11:   b = ANS_RDLEN[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: sv/cdr_ctrl.sv
module cdr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_op,
    input  logic             i_end_of_packet,
    input  cdr_pkg::t_status i_status,
    output cdr_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import cdr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   accept;

    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_REQUEST) begin
                        o_cmd.write_byte = 1'b1;
                        if (i_end_of_packet) begin
                            n_state = S_DECIDE;
                        end
                    end else if (i_status.pending) begin
                        o_cmd.pull_read = 1'b1;
                        n_state         = S_READ;
                    end else begin
                        o_cmd.emit_empty = 1'b1;
                    end
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_IDLE;
            end
            S_READ: begin
                o_cmd.emit_byte = 1'b1;
                n_state         = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

endmodule

// File: sv/cdr_datapath.sv
module cdr_datapath #(
    parameter int BUFFER_BYTES = cdr_pkg::BUFFER_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cdr_pkg::t_cmd    i_cmd,
    output cdr_pkg::t_status o_status,
    input  logic [7:0]       i_data_byte,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_wdata,
    output logic             o_strobe,
    output cdr_pkg::t_kind   o_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_final_byte,
    output logic [2:0]       o_verdict,
    output logic [9:0]       o_response_length
);
    import cdr_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rptr;
    logic [CW-1:0] r_reply_len;
    logic [31:0]   r_local_address;
    logic [7:0]    r_flags;
    logic [7:0]    r_counts [8];
    logic [7:0]    r_label;

    logic          r_strobe;
    t_kind         r_kind;
    logic [7:0]    r_out_byte;
    logic          r_final;
    logic [2:0]    r_verdict;
    logic [9:0]    r_resp_len;

    // verdict logic
    logic [15:0]   qd, an, ns, ar;
    logic [CW:0]   total_len;
    logic [2:0]    verdict;
    logic [CW+9:0] resp_len_ext;

    // readout logic
    logic [CW-1:0] req_len;
    logic [CW-1:0] tail_idx;
    logic [1:0]    addr_sel;
    logic [7:0]    resp_byte;
    logic          final_byte;

    assign o_status.pending = (r_reply_len != '0);

    always_comb begin
        qd        = {r_counts[0], r_counts[1]};
        an        = {r_counts[2], r_counts[3]};
        ns        = {r_counts[4], r_counts[5]};
        ar        = {r_counts[6], r_counts[7]};
        total_len = {1'b0, r_count} + (CW+1)'(ANSWER_BYTES);
        if (r_count < CW'(HEADER_BYTES)) begin
            verdict = VERDICT_SHORT;
        end else if (qd != 16'd1 || an != '0 || ns != '0 || ar != '0) begin
            verdict = VERDICT_COUNTS;
        end else if (r_count < CW'(HEADER_BYTES + 1) || r_label == 8'h00) begin
            verdict = VERDICT_SHORT;
        end else if ((r_flags & 8'hF8) != 8'h00) begin
            verdict = VERDICT_NOT_QUERY;
        end else if (total_len > (CW+1)'(BUFFER_BYTES)) begin
            verdict = VERDICT_TOO_LONG;
        end else begin
            verdict = VERDICT_ANSWERED;
        end
        resp_len_ext = {9'b0, total_len};
    end

    always_comb begin
        req_len    = r_reply_len - CW'(ANSWER_BYTES);
        tail_idx   = r_rptr - req_len;
        addr_sel   = 2'd3 - tail_idx[1:0];
        final_byte = ({1'b0, r_rptr} + (CW+1)'(1)) >= {1'b0, r_reply_len};
        if (r_rptr < req_len) begin
            resp_byte = r_rd_data;
            if (r_rptr == CW'(2) || r_rptr == CW'(3)) begin
                resp_byte = r_rd_data | 8'h80;
            end else if (r_rptr == CW'(6)) begin
                resp_byte = 8'h00;
            end else if (r_rptr == CW'(7)) begin
                resp_byte = 8'h01;
            end
        end else if (tail_idx < CW'(HEADER_BYTES)) begin
            resp_byte = tail_byte(tail_idx[3:0]);
        end else begin
            resp_byte = r_local_address[addr_sel*8 +: 8];
        end
    end

    // packet store and header capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_byte && r_count < CW'(BUFFER_BYTES)) begin
            mem[r_count[AW-1:0]] <= i_data_byte;
            if (r_count == CW'(2)) begin
                r_flags <= i_data_byte;
            end
            if (r_count == CW'(HEADER_BYTES)) begin
                r_label <= i_data_byte;
            end
            for (int j = 0; j < 8; j++) begin
                if (r_count == CW'(j + 4)) begin
                    r_counts[j] <= i_data_byte;
                end
            end
        end
        if (i_cmd.pull_read) begin
            r_rd_data <= mem[r_rptr[AW-1:0]];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_rptr          <= '0;
            r_reply_len     <= '0;
            r_local_address <= '0;
            r_strobe        <= 1'b0;
        end else begin
            r_strobe <= i_cmd.decide || i_cmd.emit_empty || i_cmd.emit_byte;
            if (i_cfg_we) begin
                r_local_address <= i_cfg_wdata;
            end
            if (i_cmd.write_byte) begin
                r_reply_len <= '0;
                r_rptr      <= '0;
                if (r_count < CW'(BUFFER_BYTES)) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.decide) begin
                r_count <= '0;
                if (verdict == VERDICT_ANSWERED) begin
                    r_reply_len <= total_len[CW-1:0];
                end
            end
            if (i_cmd.emit_byte) begin
                if (final_byte) begin
                    r_reply_len <= '0;
                    r_rptr      <= '0;
                end else begin
                    r_rptr <= r_rptr + CW'(1);
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_kind     <= KIND_VERDICT;
            r_out_byte <= 8'h00;
            r_final    <= 1'b0;
            r_verdict  <= verdict;
            r_resp_len <= (verdict == VERDICT_ANSWERED) ? resp_len_ext[9:0] : 10'd0;
        end else if (i_cmd.emit_empty) begin
            r_kind     <= KIND_EMPTY;
            r_out_byte <= 8'h00;
            r_final    <= 1'b0;
            r_verdict  <= VERDICT_ANSWERED;
            r_resp_len <= 10'd0;
        end else if (i_cmd.emit_byte) begin
            r_kind     <= KIND_BYTE;
            r_out_byte <= resp_byte;
            r_final    <= final_byte;
            r_verdict  <= VERDICT_ANSWERED;
            r_resp_len <= 10'd0;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_kind            = r_kind;
    assign o_out_byte        = r_out_byte;
    assign o_final_byte      = r_final;
    assign o_verdict         = r_verdict;
    assign o_response_length = r_resp_len;

endmodule

// File: sv/captive_dns_responder.sv
// Captive DNS responder. Feed a request datagram with start, op = 0, one byte per
// item, end_of_packet on the last byte; the verdict (and on an answer the response
// length) comes back as one strobed result once the decide state has run.
// Then issue op = 1 items to pull the response, one byte per item, final_byte on the
// last; a pull with nothing pending returns kind "nothing pending" in the next cycle.
// Results appear on o_strobe for exactly one cycle and cannot be held off, so the
// receiver must take every strobe. A non-final request byte and a pull with nothing
// pending leave the sequencer idle; the final byte passes a decide state (header
// checks), a pull of a pending byte a read state, as the packet store has one
// registered read port; busy covers those states. Write local_address only while idle.
module captive_dns_responder #(
    parameter int BUFFER_BYTES = cdr_pkg::BUFFER_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  logic           i_op,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_packet,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata,
    output logic           o_strobe,
    output cdr_pkg::t_kind o_kind,
    output logic [7:0]     o_out_byte,
    output logic           o_final_byte,
    output logic [2:0]     o_verdict,
    output logic [9:0]     o_response_length
);
    import cdr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: accept items, step through decide and store read
    cdr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_op           (i_op),
        .i_end_of_packet(i_end_of_packet),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_busy         (o_busy)
    );

    // packet store, header checks, response build and result registers
    cdr_datapath #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_data_byte      (i_data_byte),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_strobe         (o_strobe),
        .o_kind           (o_kind),
        .o_out_byte       (o_out_byte),
        .o_final_byte     (o_final_byte),
        .o_verdict        (o_verdict),
        .o_response_length(o_response_length)
    );

    // final request byte yields a verdict after the decide state
    a_verdict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_op == OP_REQUEST && i_end_of_packet
        |=> ##1 (o_strobe && o_kind == KIND_VERDICT))
        else $error("verdict missing after final request byte");

    // pull with a pending response yields a response byte after the store read
    a_byte_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_op == OP_PULL && status.pending
        |=> ##1 (o_strobe && o_kind == KIND_BYTE))
        else $error("response byte missing after pull");

    // pull with nothing pending answers in the next cycle
    a_empty_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_op == OP_PULL && !status.pending
        |=> (o_strobe && o_kind == KIND_EMPTY))
        else $error("nothing-pending result missing");

    // last response byte clears the pending response
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_kind == KIND_BYTE && o_final_byte |-> !status.pending)
        else $error("response still pending after final byte");

endmodule
